// File: hdl/sbdp_pkg.sv
// sbdp_pkg: shared types and constants for the sample bit depth packer
// used by sbdp_pack, sbdp_store and sample_bit_depth_packer_top

package sbdp_pkg;

	// high byte store geometry
	localparam int MAX_FRAME_SAMPLES = 4096;
	localparam int ADDR_W            = $clog2(MAX_FRAME_SAMPLES);
	localparam int CNT_W             = $clog2(MAX_FRAME_SAMPLES + 1);

	// packing depth register codes
	typedef enum logic [1:0] {
		MODE_1BIT  = 2'd0,
		MODE_4BIT  = 2'd1,
		MODE_8BIT  = 2'd2,
		MODE_16BIT = 2'd3
	} mode_t;

	localparam mode_t MODE_RESET = MODE_8BIT;

	// request kind carried on the input tuser bit
	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	// result of packing one pushed sample
	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       last;
		logic [7:0] acc_n;
		logic [2:0] fill_n;
		logic       push_hi;
		logic [7:0] hi_byte;
	} pack_res_t;

	// control from the top level into the high byte store
	typedef struct packed {
		logic       push;
		logic [7:0] hi_byte;
		logic       drain;
	} store_ctl_t;

	// status from the high byte store
	typedef struct packed {
		logic pending;
		logic last;
	} store_sts_t;

endpackage

// File: hdl/sbdp_pack.sv
// sbdp_pack: combinational packing of one pushed sample at the current depth
// depends on sbdp_pkg

module sbdp_pack (
	input  sbdp_pkg::mode_t     mode,
	input  logic signed [15:0]  sample,
	input  logic                frame_end,
	input  logic [7:0]          acc,
	input  logic [2:0]          fill,
	output sbdp_pkg::pack_res_t res
);

	logic [15:0] mag;
	logic [15:0] mapped;
	logic [7:0]  acc_bit;
	logic [7:0]  hi_nib;

	// sign-magnitude map for the sixteen-bit mode, wraps at 16 bits
	always_comb begin
		mag    = 16'(-sample);
		mapped = sample[15] ? {mag[14:0], 1'b1} : {sample[14:0], 1'b0};
	end

	assign acc_bit = acc | (8'(sample[0]) << fill);
	assign hi_nib  = {sample[3:0], 4'h0};

	// per-mode byte and next accumulator state
	always_comb begin
		res         = '0;
		res.acc_n   = acc;
		res.fill_n  = fill;
		res.hi_byte = mapped[15:8];
		unique case (mode)
			sbdp_pkg::MODE_1BIT: begin
				if (fill == 3'd7 || frame_end) begin
					res.emit   = 1'b1;
					res.data   = acc_bit;
					res.last   = frame_end;
					res.acc_n  = 8'h00;
					res.fill_n = 3'd0;
				end else begin
					res.acc_n  = acc_bit;
					res.fill_n = fill + 3'd1;
				end
			end
			sbdp_pkg::MODE_4BIT: begin
				if (fill == 3'd0) begin
					if (frame_end) begin
						// odd frame: flush the lone high nibble
						res.emit   = 1'b1;
						res.data   = hi_nib;
						res.last   = 1'b1;
						res.acc_n  = 8'h00;
						res.fill_n = 3'd0;
					end else begin
						res.acc_n  = hi_nib;
						res.fill_n = 3'd1;
					end
				end else begin
					res.emit   = 1'b1;
					res.data   = acc | {4'h0, sample[3:0]};
					res.last   = frame_end;
					res.acc_n  = 8'h00;
					res.fill_n = 3'd0;
				end
			end
			sbdp_pkg::MODE_8BIT: begin
				res.emit = 1'b1;
				res.data = sample[7:0];
				res.last = frame_end;
			end
			sbdp_pkg::MODE_16BIT: begin
				res.emit    = 1'b1;
				res.data    = mapped[7:0];
				res.last    = 1'b0;
				res.push_hi = 1'b1;
			end
			default: begin
				res.emit = 1'b0;
			end
		endcase
	end

endmodule

// File: hdl/sbdp_store.sv
// sbdp_store: high byte memory with fill count and drain pointer
// depends on sbdp_pkg; read data is registered on an accepted read request

module sbdp_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbdp_pkg::store_ctl_t ctl,
	output sbdp_pkg::store_sts_t sts,
	output logic [7:0]           rd_data
);

	logic [7:0]                  mem [sbdp_pkg::MAX_FRAME_SAMPLES];
	logic [sbdp_pkg::CNT_W-1:0]  stored_count_q;
	logic [sbdp_pkg::CNT_W-1:0]  drain_ptr_q;
	logic [sbdp_pkg::CNT_W-1:0]  drain_ptr_inc;
	logic                        not_full;
	logic                        wr_en;
	logic                        rd_en;
	logic [7:0]                  rd_q;

	assign drain_ptr_inc = drain_ptr_q + sbdp_pkg::CNT_W'(1);
	assign not_full      = stored_count_q < sbdp_pkg::CNT_W'(sbdp_pkg::MAX_FRAME_SAMPLES);
	assign sts.pending   = drain_ptr_q < stored_count_q;
	assign sts.last      = drain_ptr_inc == stored_count_q;
	assign wr_en         = ctl.push && not_full;
	assign rd_en         = ctl.drain && sts.pending;
	assign rd_data       = rd_q;

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[stored_count_q[sbdp_pkg::ADDR_W-1:0]] <= ctl.hi_byte;
		end
		if (rd_en) begin
			rd_q <= mem[drain_ptr_q[sbdp_pkg::ADDR_W-1:0]];
		end
	end

	// fill count and drain pointer, both clear after the last stored byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count_q <= '0;
			drain_ptr_q    <= '0;
		end else if (rd_en) begin
			if (sts.last) begin
				stored_count_q <= '0;
				drain_ptr_q    <= '0;
			end else begin
				drain_ptr_q <= drain_ptr_inc;
			end
		end else if (wr_en) begin
			stored_count_q <= stored_count_q + sbdp_pkg::CNT_W'(1);
		end
	end

endmodule

// File: hdl/sample_bit_depth_packer_top.sv
// sample_bit_depth_packer_top: stream top level of the sample bit depth packer
// depends on sbdp_pkg, sbdp_pack and sbdp_store

// Takes one request per clock unless the output stalls and gives at most one
// packed byte for it: the first register stage holds the packed byte, and for
// a drain the store (a single-port-per-direction memory of 4096 bytes)
// registers the high byte; the second is the output register. Pushes at depth
// 1, 4 or 8 pack into bytes; at depth 16 the low byte leaves at once and the
// high byte is kept for a later drain request, which gives planar order. High
// bytes past 4096 stored are dropped. No clearing pass is needed after reset.
module sample_bit_depth_packer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,      // pack_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // sample
	input  logic [0:0]  s_axis_tuser,   // opcode
	input  logic        s_axis_tlast,   // frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // packed_byte
	output logic        m_axis_tlast    // final_byte
);

	sbdp_pkg::mode_t     pack_mode_q;
	logic [7:0]          acc_q;
	logic [2:0]          fill_q;
	sbdp_pkg::pack_res_t pres;
	sbdp_pkg::store_ctl_t st_ctl;
	sbdp_pkg::store_sts_t st_sts;
	logic [7:0]          rd_data;
	logic                s_acc;
	logic                is_drain;
	logic                adv_s1;
	logic                valid_s1;
	logic                drain_s1;
	logic [7:0]          data_s1;
	logic                last_s1;
	logic                out_valid_q;
	logic [7:0]          out_data_q;
	logic                out_last_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_mode_q <= sbdp_pkg::MODE_RESET;
		end else if (cfg_we) begin
			pack_mode_q <= sbdp_pkg::mode_t'(cfg_wdata);
		end
	end

	// handshake
	assign adv_s1        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign is_drain      = sbdp_pkg::op_t'(s_axis_tuser[0]) == sbdp_pkg::OP_DRAIN;

	sbdp_pack u_pack (
		.mode      (pack_mode_q),
		.sample    (s_axis_tdata),
		.frame_end (s_axis_tlast),
		.acc       (acc_q),
		.fill      (fill_q),
		.res       (pres)
	);

	assign st_ctl.push    = s_acc && !is_drain && pres.push_hi;
	assign st_ctl.hi_byte = pres.hi_byte;
	assign st_ctl.drain   = s_acc && is_drain;

	sbdp_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.sts     (st_sts),
		.rd_data (rd_data)
	);

	// bit accumulator shared by the one-bit and four-bit modes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (s_acc && !is_drain) begin
			acc_q  <= pres.acc_n;
			fill_q <= pres.fill_n;
		end
	end

	// stage one: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_acc && (is_drain ? st_sts.pending : pres.emit);
		end
	end

	// stage one: payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			drain_s1 <= is_drain;
			data_s1  <= pres.data;
			last_s1  <= is_drain ? st_sts.last : pres.last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			out_data_q <= drain_s1 ? rd_data : data_s1;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// a drain with nothing stored gives no result
	a_empty_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && is_drain && !st_sts.pending) |=> !valid_s1)
		else $error("drain on empty store produced a result");

	// the eighth bit in one-bit mode always flushes the accumulator
	a_bit_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !is_drain && pack_mode_q == sbdp_pkg::MODE_1BIT && fill_q == 3'd7)
		|=> (fill_q == 3'd0 && acc_q == 8'h00 && valid_s1))
		else $error("full bit accumulator not flushed");

	// a held stage one result is not overwritten while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(data_s1) && $stable(last_s1)))
		else $error("stage one result lost under back pressure");

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking stream testbench for sample_bit_depth_packer_top
// depends on sbdp_pkg and the packer RTL; predicts every packed byte in a bit-exact model

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;

	// expected packed byte with its frame marker
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} packed_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = 2'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'd0;   // sample
	logic [0:0]  s_axis_tuser = 1'b0;    // opcode
	logic        s_axis_tlast = 1'b0;    // frame_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [7:0]  m_axis_tdata;           // packed_byte
	logic        m_axis_tlast;           // final_byte

	// packer model state
	sbdp_pkg::mode_t            pk_mode = sbdp_pkg::MODE_RESET;
	logic [7:0]                 pk_acc = 8'd0;
	logic [2:0]                 pk_fill = 3'd0;
	logic [7:0]                 hi_store [sbdp_pkg::MAX_FRAME_SAMPLES];
	logic [sbdp_pkg::CNT_W-1:0] hi_count = '0;
	logic [sbdp_pkg::CNT_W-1:0] hi_rd_ptr = '0;
	packed_byte_t               exp_bytes [$];

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_fail = 0;
	int cycle_cnt = 0;

	sample_bit_depth_packer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d bytes still expected",
				$time, cycle_cnt, exp_bytes.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// append one predicted byte to the tail of the queue
	function automatic void queue_byte(logic [7:0] d, logic f);
		packed_byte_t pb;
		pb.data = d;
		pb.fin  = f;
		exp_bytes.insert(exp_bytes.size(), pb);
	endfunction

	// model of one accepted request, queues the byte it yields
	function automatic void pack_predict(sbdp_pkg::op_t op, logic [15:0] smp, logic fe);
		logic [15:0] mag;
		logic [15:0] sm;
		logic [7:0]  hb;
		logic        hfin;
		if (op == sbdp_pkg::OP_DRAIN) begin
			if (hi_rd_ptr < hi_count) begin
				hb = hi_store[hi_rd_ptr[sbdp_pkg::ADDR_W-1:0]];
				hi_rd_ptr++;
				hfin = (hi_rd_ptr == hi_count);
				if (hfin) begin
					hi_rd_ptr = '0;
					hi_count = '0;
				end
				queue_byte(hb, hfin);
			end
			return;
		end
		case (pk_mode)
			sbdp_pkg::MODE_1BIT: begin
				pk_acc = pk_acc | (8'(smp[0]) << pk_fill);
				if (pk_fill == 3'd7 || fe) begin
					queue_byte(pk_acc, fe);
					pk_acc = 8'd0;
					pk_fill = 3'd0;
				end else begin
					pk_fill++;
				end
			end
			sbdp_pkg::MODE_4BIT: begin
				if (pk_fill == 3'd0) begin
					pk_acc = {smp[3:0], 4'd0};
					pk_fill = 3'd1;
					// odd frame: pad the low nibble with zero
					if (fe) begin
						queue_byte(pk_acc, 1'b1);
						pk_acc = 8'd0;
						pk_fill = 3'd0;
					end
				end else begin
					queue_byte(pk_acc | {4'd0, smp[3:0]}, fe);
					pk_acc = 8'd0;
					pk_fill = 3'd0;
				end
			end
			sbdp_pkg::MODE_8BIT: queue_byte(smp[7:0], fe);
			default: begin
				// sign-magnitude map, wrapped to 16 bits
				if (smp[15]) begin
					mag = 16'(-smp);
					sm = (mag << 1) | 16'd1;
				end else begin
					sm = smp << 1;
				end
				if (hi_count < sbdp_pkg::MAX_FRAME_SAMPLES) begin
					hi_store[hi_count[sbdp_pkg::ADDR_W-1:0]] = sm[15:8];
					hi_count++;
				end
				queue_byte(sm[7:0], 1'b0);
			end
		endcase
	endfunction

	// watch both handshakes and the register write
	always @(posedge clk) begin : mon
		packed_byte_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pack_predict(sbdp_pkg::op_t'(s_axis_tuser), s_axis_tdata, s_axis_tlast);
				n_accepted++;
			end
			if (cfg_we)
				pk_mode = sbdp_pkg::mode_t'(cfg_wdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (exp_bytes.size() == 0) begin
					$display("%0t: unexpected byte, expected none, got data %02h last %0b",
						$time, m_axis_tdata, m_axis_tlast);
					n_fail++;
				end else begin
					want = exp_bytes.pop_front();
					n_checked++;
					if (m_axis_tdata !== want.data) begin
						$display("%0t: packed_byte mismatch, expected %02h, got %02h",
							$time, want.data, m_axis_tdata);
						n_fail++;
					end
					if (m_axis_tlast !== want.fin) begin
						$display("%0t: final_byte mismatch, expected %0b, got %0b",
							$time, want.fin, m_axis_tlast);
						n_fail++;
					end
				end
			end
		end
	end

	// one request, with a random idle gap in front
	task automatic send_req(input sbdp_pkg::op_t op, input logic [15:0] smp, input logic fe);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= op;
		s_axis_tlast  <= fe;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// hold off until every predicted byte has come out
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (exp_bytes.size() != 0) @(posedge clk);
	endtask

	// register write while the packer is idle
	task automatic write_mode(input sbdp_pkg::mode_t m);
		wait_results();
		repeat (IDLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return $urandom_range(1) ? 16'h7FFF : 16'h8001;
			2: return 16'($signed($urandom_range(16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	// reset value, field extremes and the flush cases of every depth
	task automatic test_directed();
		// depth 8 straight out of reset
		send_req(sbdp_pkg::OP_PUSH, 16'h7FFF, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h8001, 1'b1);
		send_req(sbdp_pkg::OP_PUSH, 16'h0000, 1'b0);
		// depth 1: one full byte, then a zero partial byte flushed
		write_mode(sbdp_pkg::MODE_1BIT);
		for (int i = 0; i < 8; i++)
			send_req(sbdp_pkg::OP_PUSH, (i % 3 == 0) ? 16'h0000 : 16'hFFFF, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h0000, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'hFFFE, 1'b1);
		// depth 4: pair, then an odd frame
		write_mode(sbdp_pkg::MODE_4BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h7FFF, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h8001, 1'b1);
		send_req(sbdp_pkg::OP_PUSH, 16'h8005, 1'b1);
		// depth 16 with both signs, the most negative value and planar drains
		write_mode(sbdp_pkg::MODE_16BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h7FFF, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h8001, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h8000, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'hFFFF, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h0000, 1'b1);
		for (int i = 0; i < 6; i++)
			send_req(sbdp_pkg::OP_DRAIN, 16'($urandom), i[0]);
	endtask

	// drains ahead of frame end and drains issued at other depths
	task automatic test_drain_order();
		write_mode(sbdp_pkg::MODE_16BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h1234, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'hC000, 1'b0);
		send_req(sbdp_pkg::OP_DRAIN, 16'hFFFF, 1'b1);
		send_req(sbdp_pkg::OP_PUSH, 16'h4001, 1'b1);
		send_req(sbdp_pkg::OP_DRAIN, 16'h0000, 1'b0);
		send_req(sbdp_pkg::OP_DRAIN, 16'h0000, 1'b0);
		send_req(sbdp_pkg::OP_DRAIN, 16'h0000, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h0ABC, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'hF0F0, 1'b1);
		write_mode(sbdp_pkg::MODE_1BIT);
		send_req(sbdp_pkg::OP_DRAIN, 16'h0000, 1'b0);
		write_mode(sbdp_pkg::MODE_8BIT);
		send_req(sbdp_pkg::OP_DRAIN, 16'h0000, 1'b1);
		send_req(sbdp_pkg::OP_DRAIN, 16'h0000, 1'b0);
	endtask

	// accumulator kept across depth changes inside a frame
	task automatic test_mode_switch();
		write_mode(sbdp_pkg::MODE_1BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h0001, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h0000, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h0001, 1'b0);
		write_mode(sbdp_pkg::MODE_8BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h00A5, 1'b0);
		write_mode(sbdp_pkg::MODE_16BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h9876, 1'b0);
		write_mode(sbdp_pkg::MODE_4BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h000C, 1'b0);
		send_req(sbdp_pkg::OP_PUSH, 16'h0009, 1'b0);
		write_mode(sbdp_pkg::MODE_1BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h0001, 1'b0);
		write_mode(sbdp_pkg::MODE_4BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h0003, 1'b0);
		write_mode(sbdp_pkg::MODE_1BIT);
		send_req(sbdp_pkg::OP_PUSH, 16'h0001, 1'b1);
		write_mode(sbdp_pkg::MODE_16BIT);
		send_req(sbdp_pkg::OP_DRAIN, 16'h0000, 1'b0);
	endtask

	// random frames at random depths, with drains and some noise
	task automatic test_random_phase(input int src_pct, input int sink_pct, input int n_items);
		int start;
		int len;
		int n_drain;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		start = n_accepted;
		while (n_accepted - start < n_items) begin
			if ($urandom_range(1))
				write_mode(sbdp_pkg::mode_t'($urandom_range(3)));
			else if ($urandom_range(9) == 0)
				wait_results();
			len = ($urandom_range(7) == 0) ? $urandom_range(40) + 1 : $urandom_range(8) + 1;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(15) == 0)
					send_req(sbdp_pkg::op_t'($urandom_range(1)), 16'($urandom),
						$urandom_range(1));
				send_req(sbdp_pkg::OP_PUSH, rand_sample(), i == len - 1);
			end
			// empty the store, sometimes with one or two drains too many
			n_drain = int'(hi_count) - int'(hi_rd_ptr) + $urandom_range(2);
			for (int i = 0; i < n_drain; i++)
				send_req(sbdp_pkg::OP_DRAIN, 16'($urandom), $urandom_range(1));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_order();
		test_mode_switch();
		test_random_phase(0, 0, 190);
		test_random_phase(68, 0, 190);
		test_random_phase(0, 68, 190);
		test_random_phase(34, 34, 190);
		wait_results();
		repeat (IDLE_CYCLES) @(posedge clk);
		$display("run covered %0d requests at all four depths and four idle patterns,",
			n_accepted);
		$display("with early drains and depth changes mid frame; %0d bytes checked, %0d mismatches",
			n_checked, n_fail);
		if (n_fail == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
